>>> hdl/hrlp_pkg.sv
// Shared types, constants and helpers of the HTTP request line parser.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package hrlp_pkg;

   // Result queue between the parser front and the output stage
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUEST = 8'h3f;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7a;
   localparam logic [7:0] CASE_GAP = 8'h20;

   localparam logic [2:0] GET_LEN   = 3'd3;
   localparam logic [2:0] POST_LEN  = 3'd4;
   localparam logic [2:0] COUNT_MAX = 3'd7;

   typedef enum logic [1:0] {
      PH_METHOD = 2'd0,
      PH_PATH   = 2'd1,
      PH_QUERY  = 2'd2,
      PH_SKIP   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      MK_GET   = 2'd0,
      MK_POST  = 2'd2,
      MK_OTHER = 2'd3
   } method_type;

   typedef enum logic [2:0] {
      K_PATH   = 3'd0,
      K_KEY    = 3'd1,
      K_VALUE  = 3'd2,
      K_PAIR   = 3'd3,
      K_STATUS = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_GET_OK  = 2'd0,
      ST_GET_ERR = 2'd1,
      ST_POST    = 2'd2,
      ST_OTHER   = 2'd3
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_val;
      status_type status;
      logic       last;
   } item_type;

   // Up to two result items written into the queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      item_type   first;
      item_type   second;
   } push_type;

   function automatic item_type make_item(kind_type kind, logic [7:0] char_val,
                                          status_type status, logic last);
      item_type it;
      it.kind     = kind;
      it.char_val = char_val;
      it.status   = status;
      it.last     = last;
      return it;
   endfunction

   function automatic logic [7:0] get_char(logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h47; // G
         2'd1:    c = 8'h45; // E
         2'd2:    c = 8'h54; // T
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] post_char(logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h50; // P
         2'd1:    c = 8'h4f; // O
         2'd2:    c = 8'h53; // S
         default: c = 8'h54; // T
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hdl/hrlp_req_if.sv
// Input channel of the request line parser: one byte or end-of-line mark per beat.
// Depends on nothing.
`default_nettype none

interface hrlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_line;

   modport source (output valid, output data_byte, output end_of_line, input ready);
   modport sink   (input valid, input data_byte, input end_of_line, output ready);
endinterface

`default_nettype wire

>>> hdl/hrlp_rsp_if.sv
// Result channel of the request line parser: one tagged item per beat.
// Depends on nothing.
`default_nettype none

interface hrlp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] item_kind;
   logic [7:0] char_out;
   logic [1:0] line_status;
   logic       last_of_line;

   modport source (output valid, output item_kind, output char_out,
                   output line_status, output last_of_line, input ready);
   modport sink   (input valid, input item_kind, input char_out,
                   input line_status, input last_of_line, output ready);
endinterface

`default_nettype wire

>>> hdl/hrlp_front.sv
// Parser front: accepts request line bytes, tracks the parse state and
// produces zero to two result items per beat. Depends on hrlp_pkg, hrlp_req_if.
`default_nettype none

module hrlp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   hrlp_req_if.sink              req_chan,
   input  wire logic             space_ok,
   output hrlp_pkg::push_type    push
);

   hrlp_pkg::phase_type  phase_ff, phase_in;
   logic [1:0]           cand_ff, cand_in;      // bit0 GET, bit1 POST
   logic [2:0]           count_ff, count_in;
   hrlp_pkg::method_type kind_ff, kind_in;
   logic                 slash_ff, slash_in;
   logic                 has_eq_ff, has_eq_in;
   logic                 nonempty_ff, nonempty_in;
   logic                 err_ff, err_in;

   logic                 accept;
   logic [7:0]           b;
   logic [7:0]           upper;
   logic                 seg_open;
   logic                 close_err;
   hrlp_pkg::status_type st;
   logic [1:0]           n;
   hrlp_pkg::item_type   it0, it1;

   assign req_chan.ready = space_ok;
   assign accept         = req_chan.valid && space_ok;
   assign b              = req_chan.data_byte;
   assign upper = (b >= hrlp_pkg::CH_LOW_A && b <= hrlp_pkg::CH_LOW_Z) ?
                  b - hrlp_pkg::CASE_GAP : b;

   // A query segment that still has to be closed at a space or end of line
   assign seg_open  = (phase_ff == hrlp_pkg::PH_QUERY) && !err_ff && nonempty_ff;
   assign close_err = seg_open && !has_eq_ff;

   always_comb begin
      phase_in    = phase_ff;
      cand_in     = cand_ff;
      count_in    = count_ff;
      kind_in     = kind_ff;
      slash_in    = slash_ff;
      has_eq_in   = has_eq_ff;
      nonempty_in = nonempty_ff;
      err_in      = err_ff;
      n           = 2'd0;
      it0         = hrlp_pkg::make_item(hrlp_pkg::K_PATH, 8'h00, hrlp_pkg::ST_GET_OK, 1'b0);
      it1         = it0;
      st          = hrlp_pkg::ST_OTHER;

      if (req_chan.end_of_line) begin
         if (phase_ff == hrlp_pkg::PH_METHOD) begin
            st = hrlp_pkg::ST_OTHER;
         end else if (kind_ff == hrlp_pkg::MK_GET) begin
            st = (err_ff || close_err) ? hrlp_pkg::ST_GET_ERR : hrlp_pkg::ST_GET_OK;
         end else if (kind_ff == hrlp_pkg::MK_POST) begin
            st = hrlp_pkg::ST_POST;
         end else begin
            st = hrlp_pkg::ST_OTHER;
         end
         if (seg_open && has_eq_ff) begin
            it0 = hrlp_pkg::make_item(hrlp_pkg::K_PAIR, 8'h00, hrlp_pkg::ST_GET_OK, 1'b0);
            it1 = hrlp_pkg::make_item(hrlp_pkg::K_STATUS, 8'h00, st, 1'b1);
            n   = 2'd2;
         end else begin
            it0 = hrlp_pkg::make_item(hrlp_pkg::K_STATUS, 8'h00, st, 1'b1);
            n   = 2'd1;
         end
         // return to the start-of-line state
         phase_in    = hrlp_pkg::PH_METHOD;
         cand_in     = 2'b11;
         count_in    = 3'd0;
         kind_in     = hrlp_pkg::MK_OTHER;
         slash_in    = 1'b0;
         has_eq_in   = 1'b0;
         nonempty_in = 1'b0;
         err_in      = 1'b0;
      end else begin
         case (phase_ff)
            hrlp_pkg::PH_METHOD: begin
               if (b == hrlp_pkg::CH_SPACE) begin
                  if (cand_ff[0] && count_ff == hrlp_pkg::GET_LEN) begin
                     kind_in  = hrlp_pkg::MK_GET;
                     phase_in = hrlp_pkg::PH_PATH;
                  end else if (cand_ff[1] && count_ff == hrlp_pkg::POST_LEN) begin
                     kind_in  = hrlp_pkg::MK_POST;
                     phase_in = hrlp_pkg::PH_PATH;
                  end else begin
                     kind_in  = hrlp_pkg::MK_OTHER;
                     phase_in = hrlp_pkg::PH_SKIP;
                  end
               end else begin
                  if (count_ff >= hrlp_pkg::GET_LEN ||
                      hrlp_pkg::get_char(count_ff[1:0]) != upper) begin
                     cand_in[0] = 1'b0;
                  end
                  if (count_ff >= hrlp_pkg::POST_LEN ||
                      hrlp_pkg::post_char(count_ff[1:0]) != upper) begin
                     cand_in[1] = 1'b0;
                  end
                  if (count_ff < hrlp_pkg::COUNT_MAX) begin
                     count_in = count_ff + 3'd1;
                  end
               end
            end
            hrlp_pkg::PH_PATH: begin
               if (kind_ff != hrlp_pkg::MK_GET) begin
                  if (b == hrlp_pkg::CH_SPACE) begin
                     phase_in = hrlp_pkg::PH_SKIP;
                  end else begin
                     it0 = hrlp_pkg::make_item(hrlp_pkg::K_PATH, b, hrlp_pkg::ST_GET_OK, 1'b0);
                     n   = 2'd1;
                  end
               end else if (b == hrlp_pkg::CH_SPACE) begin
                  // drop a trailing slash
                  slash_in = 1'b0;
                  phase_in = hrlp_pkg::PH_SKIP;
               end else begin
                  // release a held slash first, then handle this byte
                  if (slash_ff) begin
                     it0 = hrlp_pkg::make_item(hrlp_pkg::K_PATH, hrlp_pkg::CH_SLASH,
                                               hrlp_pkg::ST_GET_OK, 1'b0);
                  end
                  slash_in = 1'b0;
                  if (b == hrlp_pkg::CH_QUEST) begin
                     phase_in    = hrlp_pkg::PH_QUERY;
                     has_eq_in   = 1'b0;
                     nonempty_in = 1'b0;
                     n           = {1'b0, slash_ff};
                  end else if (b == hrlp_pkg::CH_SLASH) begin
                     slash_in = 1'b1;
                     n        = {1'b0, slash_ff};
                  end else if (slash_ff) begin
                     it1 = hrlp_pkg::make_item(hrlp_pkg::K_PATH, b, hrlp_pkg::ST_GET_OK, 1'b0);
                     n   = 2'd2;
                  end else begin
                     it0 = hrlp_pkg::make_item(hrlp_pkg::K_PATH, b, hrlp_pkg::ST_GET_OK, 1'b0);
                     n   = 2'd1;
                  end
               end
            end
            hrlp_pkg::PH_QUERY: begin
               if (b == hrlp_pkg::CH_SPACE) begin
                  if (seg_open && has_eq_ff) begin
                     it0 = hrlp_pkg::make_item(hrlp_pkg::K_PAIR, 8'h00,
                                               hrlp_pkg::ST_GET_OK, 1'b0);
                     n   = 2'd1;
                  end
                  if (close_err) begin
                     err_in = 1'b1;
                  end
                  phase_in = hrlp_pkg::PH_SKIP;
               end else if (err_ff) begin
                  // ignore the rest of the query
               end else if (b == hrlp_pkg::CH_AMP) begin
                  if (has_eq_ff) begin
                     it0 = hrlp_pkg::make_item(hrlp_pkg::K_PAIR, 8'h00,
                                               hrlp_pkg::ST_GET_OK, 1'b0);
                     n   = 2'd1;
                  end else begin
                     err_in = 1'b1;
                  end
                  has_eq_in   = 1'b0;
                  nonempty_in = 1'b0;
               end else if (b == hrlp_pkg::CH_EQ && !has_eq_ff) begin
                  has_eq_in   = 1'b1;
                  nonempty_in = 1'b1;
               end else begin
                  nonempty_in = 1'b1;
                  it0 = hrlp_pkg::make_item(has_eq_ff ? hrlp_pkg::K_VALUE : hrlp_pkg::K_KEY,
                                            b, hrlp_pkg::ST_GET_OK, 1'b0);
                  n   = 2'd1;
               end
            end
            default: begin
               // skip to end of line
            end
         endcase
      end
   end

   assign push.count  = accept ? n : 2'd0;
   assign push.first  = it0;
   assign push.second = it1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= hrlp_pkg::PH_METHOD;
         cand_ff     <= 2'b11;
         count_ff    <= 3'd0;
         kind_ff     <= hrlp_pkg::MK_OTHER;
         slash_ff    <= 1'b0;
         has_eq_ff   <= 1'b0;
         nonempty_ff <= 1'b0;
         err_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         cand_ff     <= cand_in;
         count_ff    <= count_in;
         kind_ff     <= kind_in;
         slash_ff    <= slash_in;
         has_eq_ff   <= has_eq_in;
         nonempty_ff <= nonempty_in;
         err_ff      <= err_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/hrlp_queue.sv
// Result queue: takes up to two items a cycle from the front, gives one a
// cycle to the output stage. Depends on hrlp_pkg.
`default_nettype none

module hrlp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hrlp_pkg::push_type  push,
   output      logic                space_ok,
   output      logic                not_empty,
   output      hrlp_pkg::item_type  head,
   input  wire logic                pop
);

   hrlp_pkg::item_type               mem [hrlp_pkg::QUEUE_DEPTH];
   logic [hrlp_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hrlp_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hrlp_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [hrlp_pkg::PTR_W-1:0]       wr_next;

   // Room for the worst case of two items from one beat
   assign space_ok  = count_ff <= hrlp_pkg::CNT_W'(hrlp_pkg::QUEUE_DEPTH - 2);
   assign not_empty = count_ff != '0;
   assign head      = mem[rd_ptr_ff];

   assign wr_next   = wr_ptr_ff + hrlp_pkg::PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + hrlp_pkg::PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + hrlp_pkg::PTR_W'(pop);
   assign count_in  = count_ff + hrlp_pkg::CNT_W'(push.count) - hrlp_pkg::CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/hrlp_back.sv
// Output stage: moves queued items into the result register and holds each
// one until the receiver takes the beat. Depends on hrlp_pkg, hrlp_rsp_if.
`default_nettype none

module hrlp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                not_empty,
   input  wire hrlp_pkg::item_type  head,
   output      logic                pop,
   hrlp_rsp_if.source               rsp_chan
);

   logic               valid_ff, valid_in;
   hrlp_pkg::item_type data_ff;
   logic               load;

   // Refill when the register is empty or its beat goes out this cycle
   assign load     = not_empty && (!valid_ff || rsp_chan.ready);
   assign pop      = load;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.item_kind    = data_ff.kind;
   assign rsp_chan.char_out     = data_ff.char_val;
   assign rsp_chan.line_status  = data_ff.status;
   assign rsp_chan.last_of_line = data_ff.last;

endmodule

`default_nettype wire

>>> hdl/http_request_line_parser_top.sv
// HTTP request line parser, top level.
// req_chan carries one byte of the request line per beat, or an end-of-line
// mark (end_of_line high, data_byte ignored). rsp_chan carries tagged items:
// path, key and value bytes, pair ends, and one final status item per line
// with last_of_line high.
// The first item caused by a beat goes into the result queue, then into the
// output register before it is valid. Throughput: one byte per cycle; a beat
// that causes two items (released slash plus path byte, or pair end plus
// status) leaves one extra item in the four-entry result queue, which absorbs
// it before the input is held off. The input is ready whenever the queue has
// room for two items, so a stalled receiver stops the input only once fewer
// than two entries are free; nothing is dropped. Reset clears the parse state
// to the start of a line and empties the queue and the output register.
// Depends on hrlp_pkg, hrlp_req_if, hrlp_rsp_if, hrlp_front, hrlp_queue,
// hrlp_back.
`default_nettype none

module http_request_line_parser_top (
   input  wire logic  clock,
   input  wire logic  reset,
   hrlp_req_if.sink   req_chan,
   hrlp_rsp_if.source rsp_chan
);

   hrlp_pkg::push_type push;
   hrlp_pkg::item_type head;
   logic               space_ok;
   logic               not_empty;
   logic               pop;

   hrlp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .space_ok (space_ok),
      .push     (push)
   );

   hrlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop)
   );

   hrlp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for http_request_line_parser_top: directed and random request lines,
// results predicted per accepted beat and compared in order. Uses hrlp_pkg and the
// hrlp_req_if / hrlp_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [23:0] WORD_GET  = "GET";
   localparam logic [31:0] WORD_POST = "POST";
   localparam int RANDOM_BEATS = 1250;
   localparam int LONG_HOLD_AT = 600;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct {
      logic [7:0] data_byte;
      logic       end_of_line;
      bit         drain;
   } line_beat_type;

   logic clock;
   logic reset;

   hrlp_req_if req_if ();
   hrlp_rsp_if rsp_if ();

   http_request_line_parser_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   line_beat_type        pending_beats[$];
   hrlp_pkg::item_type   expected_items[$];
   int                   mismatches;
   int                   beats_accepted;
   logic                 req_fired;

   // predicted parser state
   hrlp_pkg::phase_type  ps_phase;
   logic [1:0]           cand;
   logic [2:0]           mcount;
   hrlp_pkg::method_type mkind;
   logic                 slash_held;
   logic                 seg_eq;
   logic                 seg_nonempty;
   logic                 perr;

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- prediction ----------------

   task automatic push_item(hrlp_pkg::kind_type k, logic [7:0] c, hrlp_pkg::status_type s,
                            logic l);
      hrlp_pkg::item_type it;
      it.kind     = k;
      it.char_val = c;
      it.status   = s;
      it.last     = l;
      expected_items.push_back(it);
   endtask

   task automatic clear_line();
      ps_phase     = hrlp_pkg::PH_METHOD;
      cand         = 2'b11;
      mcount       = '0;
      mkind        = hrlp_pkg::MK_OTHER;
      slash_held   = 1'b0;
      seg_eq       = 1'b0;
      seg_nonempty = 1'b0;
      perr         = 1'b0;
   endtask

   task automatic close_segment();
      if (!perr && seg_nonempty) begin
         if (seg_eq) push_item(hrlp_pkg::K_PAIR, 8'h00, hrlp_pkg::ST_GET_OK, 1'b0);
         else perr = 1'b1;
      end
   endtask

   task automatic parse_beat(logic [7:0] b, logic eol);
      logic [7:0] up;
      hrlp_pkg::status_type st;
      if (eol) begin
         if (ps_phase == hrlp_pkg::PH_QUERY) close_segment();
         if (ps_phase == hrlp_pkg::PH_METHOD) st = hrlp_pkg::ST_OTHER;
         else if (mkind == hrlp_pkg::MK_GET)
            st = perr ? hrlp_pkg::ST_GET_ERR : hrlp_pkg::ST_GET_OK;
         else if (mkind == hrlp_pkg::MK_POST) st = hrlp_pkg::ST_POST;
         else st = hrlp_pkg::ST_OTHER;
         push_item(hrlp_pkg::K_STATUS, 8'h00, st, 1'b1);
         clear_line();
      end else begin
         case (ps_phase)
            hrlp_pkg::PH_METHOD: begin
               if (b == hrlp_pkg::CH_SPACE) begin
                  if (cand[0] && mcount == hrlp_pkg::GET_LEN) mkind = hrlp_pkg::MK_GET;
                  else if (cand[1] && mcount == hrlp_pkg::POST_LEN) mkind = hrlp_pkg::MK_POST;
                  else mkind = hrlp_pkg::MK_OTHER;
                  ps_phase = (mkind == hrlp_pkg::MK_OTHER) ? hrlp_pkg::PH_SKIP
                                                           : hrlp_pkg::PH_PATH;
               end else begin
                  up = (b >= hrlp_pkg::CH_LOW_A && b <= hrlp_pkg::CH_LOW_Z) ?
                       b - hrlp_pkg::CASE_GAP : b;
                  if (mcount >= hrlp_pkg::GET_LEN || up != WORD_GET[23 - 8*mcount -: 8])
                     cand[0] = 1'b0;
                  if (mcount >= hrlp_pkg::POST_LEN || up != WORD_POST[31 - 8*mcount -: 8])
                     cand[1] = 1'b0;
                  if (mcount < hrlp_pkg::COUNT_MAX) mcount = mcount + 1'b1;
               end
            end
            hrlp_pkg::PH_PATH: begin
               if (mkind != hrlp_pkg::MK_GET) begin
                  if (b == hrlp_pkg::CH_SPACE) ps_phase = hrlp_pkg::PH_SKIP;
                  else push_item(hrlp_pkg::K_PATH, b, hrlp_pkg::ST_GET_OK, 1'b0);
               end else if (b == hrlp_pkg::CH_SPACE) begin
                  // a held slash at the end of a GET path is dropped
                  slash_held = 1'b0;
                  ps_phase   = hrlp_pkg::PH_SKIP;
               end else begin
                  if (slash_held) begin
                     push_item(hrlp_pkg::K_PATH, hrlp_pkg::CH_SLASH, hrlp_pkg::ST_GET_OK, 1'b0);
                     slash_held = 1'b0;
                  end
                  if (b == hrlp_pkg::CH_QUEST) begin
                     ps_phase     = hrlp_pkg::PH_QUERY;
                     seg_eq       = 1'b0;
                     seg_nonempty = 1'b0;
                  end else if (b == hrlp_pkg::CH_SLASH) begin
                     slash_held = 1'b1;
                  end else begin
                     push_item(hrlp_pkg::K_PATH, b, hrlp_pkg::ST_GET_OK, 1'b0);
                  end
               end
            end
            hrlp_pkg::PH_QUERY: begin
               if (b == hrlp_pkg::CH_SPACE) begin
                  close_segment();
                  ps_phase = hrlp_pkg::PH_SKIP;
               end else if (perr) begin
                  // drop the rest of the query
               end else if (b == hrlp_pkg::CH_AMP) begin
                  if (seg_eq) push_item(hrlp_pkg::K_PAIR, 8'h00, hrlp_pkg::ST_GET_OK, 1'b0);
                  else perr = 1'b1;
                  seg_eq       = 1'b0;
                  seg_nonempty = 1'b0;
               end else if (b == hrlp_pkg::CH_EQ && !seg_eq) begin
                  seg_eq       = 1'b1;
                  seg_nonempty = 1'b1;
               end else begin
                  seg_nonempty = 1'b1;
                  if (seg_eq) push_item(hrlp_pkg::K_VALUE, b, hrlp_pkg::ST_GET_OK, 1'b0);
                  else push_item(hrlp_pkg::K_KEY, b, hrlp_pkg::ST_GET_OK, 1'b0);
               end
            end
            default: begin
            end
         endcase
      end
   endtask

   // ---------------- stimulus building ----------------

   task automatic add_beat(logic [7:0] b, logic eol);
      line_beat_type lb;
      lb.data_byte   = b;
      lb.end_of_line = eol;
      lb.drain       = 1'b0;
      pending_beats.push_back(lb);
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b0);
   endtask

   task automatic add_eol();
      add_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] any_case(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5a && $urandom_range(0, 1) == 1)
         return c + hrlp_pkg::CASE_GAP;
      return c;
   endfunction

   // any byte except the delimiters
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      if ($urandom_range(0, 2) == 0) c = 8'($urandom_range(0, 255));
      else c = hrlp_pkg::CH_LOW_A + 8'($urandom_range(0, 25));
      if (c == hrlp_pkg::CH_SPACE || c == hrlp_pkg::CH_QUEST || c == hrlp_pkg::CH_AMP ||
          c == hrlp_pkg::CH_EQ || c == hrlp_pkg::CH_SLASH)
         c = 8'h7e;
      return c;
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 7))
         0:       return hrlp_pkg::CH_SPACE;
         1:       return hrlp_pkg::CH_QUEST;
         2:       return hrlp_pkg::CH_AMP;
         3:       return hrlp_pkg::CH_EQ;
         4:       return hrlp_pkg::CH_SLASH;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_random_line();
      string near_miss[6] = '{"GE", "GETT", "POS", "POSTS", "PUT", "G"};
      string word;
      int    pick;
      bit    is_get;
      int    nseg;
      if ($urandom_range(0, 9) == 0) begin
         // noise line
         repeat ($urandom_range(0, 12)) add_beat(noise_char(), 1'b0);
         add_eol();
         return;
      end
      pick   = $urandom_range(0, 9);
      is_get = 1'b0;
      if (pick <= 4) begin
         word   = "GET";
         is_get = 1'b1;
      end else if (pick <= 7) begin
         word = "POST";
      end else if (pick == 8) begin
         word = near_miss[$urandom_range(0, 5)];
      end else begin
         word = "";
         repeat ($urandom_range(0, 9)) word = {word, string'(plain_char())};
      end
      for (int i = 0; i < word.len(); i++) add_beat(any_case(word[i]), 1'b0);
      if ($urandom_range(0, 15) == 0) begin
         add_eol();
         return;
      end
      add_beat(hrlp_pkg::CH_SPACE, 1'b0);
      repeat ($urandom_range(0, 6)) begin
         pick = $urandom_range(0, 9);
         if (pick <= 2) add_beat(hrlp_pkg::CH_SLASH, 1'b0);
         else if (pick == 3 && !is_get) add_beat(hrlp_pkg::CH_QUEST, 1'b0);
         else add_beat(plain_char(), 1'b0);
      end
      if (is_get && $urandom_range(0, 3) != 0) begin
         add_beat(hrlp_pkg::CH_QUEST, 1'b0);
         nseg = $urandom_range(0, 4);
         for (int s = 0; s < nseg; s++) begin
            if (s > 0) add_beat(hrlp_pkg::CH_AMP, 1'b0);
            repeat ($urandom_range(0, 3)) add_beat(plain_char(), 1'b0);
            if ($urandom_range(0, 7) != 0) begin
               add_beat(hrlp_pkg::CH_EQ, 1'b0);
               repeat ($urandom_range(0, 3)) begin
                  if ($urandom_range(0, 5) == 0) add_beat(hrlp_pkg::CH_EQ, 1'b0);
                  else add_beat(plain_char(), 1'b0);
               end
            end
         end
         if ($urandom_range(0, 5) == 0) add_beat(hrlp_pkg::CH_AMP, 1'b0);
      end
      if ($urandom_range(0, 2) == 0) begin
         add_beat(hrlp_pkg::CH_SPACE, 1'b0);
         repeat ($urandom_range(0, 3)) add_beat(noise_char(), 1'b0);
      end
      add_eol();
   endtask

   // ---------------- driver ----------------

   int gap_left;
   int burst_left;

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left     = 0;
         burst_left   = 0;
      end else if (!(req_if.valid && !req_fired)) begin
         if (req_fired) void'(pending_beats.pop_front());
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid     <= 1'b0;
            req_if.data_byte <= 8'($urandom_range(0, 255));
         end else if (pending_beats.size() == 0 ||
                      (pending_beats[0].drain && expected_items.size() != 0)) begin
            // hold until the parser has emptied out
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid       <= 1'b1;
            req_if.data_byte   <= pending_beats[0].data_byte;
            req_if.end_of_line <= pending_beats[0].end_of_line;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                        : $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // ---------------- receiver ----------------

   int  hold_left;
   int  rx_cycle;
   int  rx_mode;
   bit  long_hold_done;

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready   <= 1'b0;
         hold_left      = 0;
         rx_cycle       = 0;
         rx_mode        = 0;
         long_hold_done = 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!long_hold_done && beats_accepted >= LONG_HOLD_AT) begin
            // long back-pressure so the result queue fills and the input stalls
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES;
            rsp_if.ready   <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 9) < 7);
               2:       rsp_if.ready <= ($urandom_range(0, 9) < 3);
               default: rsp_if.ready <= (rx_cycle % 4 != 0);
            endcase
         end
      end
   end

   // ---------------- monitor and checker ----------------

   always @(posedge clock) begin
      hrlp_pkg::item_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            parse_beat(req_if.data_byte, req_if.end_of_line);
            beats_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_items.size() == 0) begin
               $error("unexpected result: kind %0d char %h status %0d last %0d",
                      rsp_if.item_kind, rsp_if.char_out, rsp_if.line_status,
                      rsp_if.last_of_line);
               mismatches++;
            end else begin
               want = expected_items.pop_front();
               if (rsp_if.item_kind !== want.kind) begin
                  $error("item_kind: expected %0d, got %0d", want.kind, rsp_if.item_kind);
                  mismatches++;
               end
               if (rsp_if.char_out !== want.char_val) begin
                  $error("char_out: expected %h, got %h", want.char_val, rsp_if.char_out);
                  mismatches++;
               end
               if (rsp_if.line_status !== want.status) begin
                  $error("line_status: expected %0d, got %0d", want.status,
                         rsp_if.line_status);
                  mismatches++;
               end
               if (rsp_if.last_of_line !== want.last) begin
                  $error("last_of_line: expected %0d, got %0d", want.last,
                         rsp_if.last_of_line);
                  mismatches++;
               end
            end
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      int drain_idx;
      req_if.valid       = 1'b0;
      req_if.data_byte   = 8'h00;
      req_if.end_of_line = 1'b0;
      rsp_if.ready       = 1'b0;
      req_fired          = 1'b0;
      mismatches         = 0;
      beats_accepted     = 0;
      reset              = 1'b1;
      clear_line();

      // lower-case method, slash released by '?', pair end together with status
      add_text("get /?a=b");
      add_eol();
      // trailing slash dropped, line ends right after the closing space
      add_text("GET x/ ");
      add_eol();
      // empty path, empty segment before '&'
      add_text("GET ?&");
      add_eol();
      // POST path keeps '?' and '/'
      add_text("POST ?/");
      add_eol();
      // no space in the line, extreme byte values
      add_beat(8'hff, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'hff, 1'b1);

      drain_idx = pending_beats.size();
      while (pending_beats.size() - drain_idx < RANDOM_BEATS) add_random_line();
      pending_beats[drain_idx].drain = 1'b1;

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      while (expected_items.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
